// File: rtl/qra_pkg.sv
// Shared widths, register indexes and result codes for the quadratic roots and area unit.
// Used by the top level, the pipelined square root and the testbench.
package qra_pkg;

   // Field widths.
   localparam int COEF_W  = 24;
   localparam int BOUND_W = 24;
   localparam int AREA_W  = 56;
   localparam int ROOT_W  = 32;
   localparam int CNT_W   = 2;
   localparam int CSR_W   = 2;

   // Exact antiderivative arithmetic runs on this width.
   localparam int WIDE_W = 128;

   // Square root operand and result widths.
   localparam int SQ_IN_W  = 64;
   localparam int SQ_OUT_W = 32;

   // Configuration register indexes.
   localparam logic [CSR_W-1:0] CSR_COEF_QUAD  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_COEF_LIN   = 2'd1;
   localparam logic [CSR_W-1:0] CSR_COEF_CONST = 2'd2;

   // Real root count codes.
   localparam logic [CNT_W-1:0] ROOTS_NONE = 2'd0;
   localparam logic [CNT_W-1:0] ROOTS_ONE  = 2'd1;
   localparam logic [CNT_W-1:0] ROOTS_TWO  = 2'd2;

endpackage

// File: rtl/qra_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on qra_pkg for operand widths.
module qra_sqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [qra_pkg::SQ_IN_W-1:0]   in_value,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [qra_pkg::SQ_OUT_W-1:0]  out_root,
   output logic [SIDE_W-1:0]             out_side
);
   localparam int STEPS = qra_pkg::SQ_OUT_W;
   localparam int VW    = qra_pkg::SQ_IN_W;

   logic              vld_ff  [STEPS];
   logic [VW-1:0]     val_ff  [STEPS];
   logic [VW-1:0]     res_ff  [STEPS];
   logic [SIDE_W-1:0] side_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [VW-1:0] BIT = VW'(1) << (VW - 2 - 2 * k);
      logic [VW-1:0]     val_cur;
      logic [VW-1:0]     res_cur;
      logic [VW-1:0]     trial;
      logic [VW-1:0]     val_in;
      logic [VW-1:0]     res_in;
      logic              vld_cur;
      logic [SIDE_W-1:0] side_cur;

      if (k == 0) begin : g_first
         assign val_cur  = in_value;
         assign res_cur  = '0;
         assign vld_cur  = in_valid;
         assign side_cur = in_side;
      end else begin : g_next
         assign val_cur  = val_ff[k-1];
         assign res_cur  = res_ff[k-1];
         assign vld_cur  = vld_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      // One digit of the restoring square root.
      always_comb begin
         trial = res_cur + BIT;
         if (val_cur >= trial) begin
            val_in = val_cur - trial;
            res_in = (res_cur >> 1) + BIT;
         end else begin
            val_in = val_cur;
            res_in = res_cur >> 1;
         end
      end

      // Stage valid.
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_cur;
         end
      end

      // Stage payload.
      always_ff @(posedge clock) begin
         if (en) begin
            val_ff[k]  <= val_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign out_root  = res_ff[STEPS-1][qra_pkg::SQ_OUT_W-1:0];
   assign out_side  = side_ff[STEPS-1];

endmodule

// File: rtl/qra_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// The divisor must hold while words are in flight. Depends on no package items.
module qra_div #(
   parameter int NUM_W  = 50,
   parameter int DEN_W  = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  quot,
   output logic [SIDE_W-1:0] out_side
);
   logic              vld_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  qd_ff   [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_step
      logic [DEN_W-1:0]  rem_cur;
      logic [NUM_W-1:0]  qd_cur;
      logic              vld_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  qd_in;

      if (k == 0) begin : g_first
         assign rem_cur  = '0;
         assign qd_cur   = num;
         assign vld_cur  = in_valid;
         assign side_cur = in_side;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign qd_cur   = qd_ff[k-1];
         assign vld_cur  = vld_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      // Bring down the next dividend bit and try the subtraction.
      always_comb begin
         trial  = {rem_cur, qd_cur[NUM_W-1]};
         diff   = trial - {1'b0, den};
         ge     = (trial >= {1'b0, den});
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         qd_in  = {qd_cur[NUM_W-2:0], ge};
      end

      // Stage valid.
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_cur;
         end
      end

      // Stage payload.
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            qd_ff[k]   <= qd_in;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign quot      = qd_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// File: rtl/quadratic_roots_and_area_unit.sv
// Top level of the quadratic roots and absolute area unit.
// Depends on qra_pkg, qra_sqrt and qra_div.
//
//   port group  direction  handshake             word
//   req_        in         req_valid/req_stall   bound_from, bound_to
//   rsp_        out        rsp_valid/rsp_stall   area, root count, roots, saturated
//   csr_        in         csr_write             csr_index, csr_wdata
//
// One word enters per cycle while the result side does not stall. Words pass through the
// 32-stage square root, the (34 + FRAC_BITS)-stage root dividers, eight area stages and
// a two-stage halving and multiply by a reciprocal of three at the end of the area path.
// Reset is synchronous; it restores the coefficients and empties the pipeline.
// A stall on the result side freezes the whole pipeline; nothing is lost or repeated.
module quadratic_roots_and_area_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [qra_pkg::BOUND_W-1:0]   req_bound_from,
   input  logic signed [qra_pkg::BOUND_W-1:0]   req_bound_to,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [qra_pkg::AREA_W-1:0]           rsp_area,
   output logic [qra_pkg::CNT_W-1:0]            rsp_real_root_count,
   output logic signed [qra_pkg::ROOT_W-1:0]    rsp_root_first,
   output logic signed [qra_pkg::ROOT_W-1:0]    rsp_root_second,
   output logic signed [qra_pkg::ROOT_W-1:0]    rsp_root_imag,
   output logic                                 rsp_saturated,
   input  logic                                 csr_write,
   input  logic [qra_pkg::CSR_W-1:0]            csr_index,
   input  logic [qra_pkg::COEF_W-1:0]           csr_wdata
);
   localparam int CW     = qra_pkg::COEF_W;
   localparam int BW     = qra_pkg::BOUND_W;
   localparam int RW     = qra_pkg::ROOT_W;
   localparam int WW     = qra_pkg::WIDE_W;
   localparam int NUMS_W = 34;
   localparam int DVD_W  = NUMS_W + FRAC_BITS;
   localparam int DEN_W  = CW + 8;
   localparam int NPT    = 4;
   localparam int NSEG   = 3;
   localparam int ESTG   = 8;
   localparam int RC_SHIFT = 59;
   localparam logic [CW-1:0]    COEF_ONE = CW'(1) << FRAC_BITS;
   localparam logic [WW-1:0]    HALF     = WW'(3) << (3 * FRAC_BITS);
   localparam logic [63:0]      AREA_LIM = 64'd6 << qra_pkg::AREA_W;
   localparam logic [DVD_W-1:0] NEG_LIM  = DVD_W'(64'h8000_0000);
   localparam logic [DVD_W-1:0] POS_LIM  = DVD_W'(64'h7FFF_FFFF);
   // Ceiling of 2^59 / 3; exact floor division by three for operands below 2^58.
   localparam logic [57:0]      RECIP3   = 58'h2AA_AAAA_AAAA_AAAB;

   typedef struct packed {
      logic [BW-1:0] lo_bound;
      logic [BW-1:0] hi_bound;
      logic          dneg;
      logic          dzero;
   } sq_side_type;

   typedef struct packed {
      sq_side_type base;
      logic        neg_first;
      logic        neg_second;
   } div_side_type;

   typedef struct packed {
      logic [qra_pkg::CNT_W-1:0] count;
      logic [RW-1:0]             first;
      logic [RW-1:0]             second;
      logic [RW-1:0]             imag;
      logic                      sat;
   } roots_type;

   typedef struct packed {
      roots_type roots;
      logic      area_sat;
   } area_side_type;

   // Coefficient registers.
   logic signed [CW-1:0] coef_quad_ff, coef_lin_ff, coef_const_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_quad_ff  <= COEF_ONE;
         coef_lin_ff   <= '0;
         coef_const_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            qra_pkg::CSR_COEF_QUAD: begin
               if (csr_wdata != '0) coef_quad_ff <= csr_wdata;
            end
            qra_pkg::CSR_COEF_LIN: begin
               coef_lin_ff <= csr_wdata;
            end
            qra_pkg::CSR_COEF_CONST: begin
               coef_const_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Coefficient magnitudes; the user must hold them stable while words are in flight.
   logic [CW-1:0] amag, bmag, cmag;
   assign amag = coef_quad_ff[CW-1]  ? CW'(0) - coef_quad_ff  : coef_quad_ff;
   assign bmag = coef_lin_ff[CW-1]   ? CW'(0) - coef_lin_ff   : coef_lin_ff;
   assign cmag = coef_const_ff[CW-1] ? CW'(0) - coef_const_ff : coef_const_ff;

   // The pipeline moves whenever the output register can be refilled.
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // Stage one: order the bounds, square b and form a*c.
   logic                   s1_vld_ff;
   logic signed [BW-1:0]   s1_lo_ff, s1_hi_ff;
   logic signed [2*CW-1:0] s1_bb_ff, s1_ac_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_lo_ff <= (req_bound_to < req_bound_from) ? req_bound_to : req_bound_from;
         s1_hi_ff <= (req_bound_to < req_bound_from) ? req_bound_from : req_bound_to;
         s1_bb_ff <= coef_lin_ff * coef_lin_ff;
         s1_ac_ff <= coef_quad_ff * coef_const_ff;
      end
   end

   // Stage two: discriminant and the square root operand.
   logic signed [2*CW+2:0] disc;
   logic [2*CW+2:0]        disc_mag;
   logic                   s2_vld_ff;
   logic [qra_pkg::SQ_IN_W-1:0] s2_sq_ff;
   sq_side_type            s2_side_ff;

   assign disc     = {{3{s1_bb_ff[2*CW-1]}}, s1_bb_ff} - {s1_ac_ff[2*CW-1], s1_ac_ff, 2'b00};
   assign disc_mag = disc[2*CW+2] ? (2*CW+3)'(0) - disc : disc;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_sq_ff            <= {disc_mag[2*CW+1:0], 14'b0};
         s2_side_ff.lo_bound <= s1_lo_ff;
         s2_side_ff.hi_bound <= s1_hi_ff;
         s2_side_ff.dneg     <= disc[2*CW+2];
         s2_side_ff.dzero    <= (disc == '0);
      end
   end

   // Square root of |d| with seven extra fraction bits.
   logic                         sq_vld;
   logic [qra_pkg::SQ_OUT_W-1:0] sq_root;
   sq_side_type                  sq_side;

   qra_sqrt #(
      .SIDE_W ($bits(sq_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s2_vld_ff),
      .in_value  (s2_sq_ff),
      .in_side   (s2_side_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Root numerators and rounded dividends.
   logic signed [NUMS_W-1:0] nb, sq_ext, num_first, num_second;
   logic [NUMS_W-1:0]        mag_first, mag_second;
   logic [DVD_W-1:0]         round_add;
   logic                     n1_vld_ff;
   logic [DVD_W-1:0]         n1_dvd1_ff, n1_dvd2_ff;
   div_side_type             n1_side_ff;

   assign nb         = NUMS_W'(0) - ({{(NUMS_W-CW){coef_lin_ff[CW-1]}}, coef_lin_ff} <<< 7);
   assign sq_ext     = {2'b00, sq_root};
   assign num_first  = sq_side.dneg ? nb : nb - sq_ext;
   assign num_second = sq_side.dneg ? sq_ext : nb + sq_ext;
   assign mag_first  = num_first[NUMS_W-1]  ? NUMS_W'(0) - num_first  : num_first;
   assign mag_second = num_second[NUMS_W-1] ? NUMS_W'(0) - num_second : num_second;
   assign round_add  = DVD_W'(amag) << 7;

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_vld_ff <= 1'b0;
      end else if (adv) begin
         n1_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_dvd1_ff            <= (DVD_W'(mag_first) << FRAC_BITS) + round_add;
         n1_dvd2_ff            <= (DVD_W'(mag_second) << FRAC_BITS) + round_add;
         n1_side_ff.base       <= sq_side;
         n1_side_ff.neg_first  <= num_first[NUMS_W-1] ^ coef_quad_ff[CW-1];
         n1_side_ff.neg_second <= num_second[NUMS_W-1] ^ coef_quad_ff[CW-1];
      end
   end

   // Two root dividers run side by side; the second carries its own sign.
   logic [DEN_W-1:0] root_den;
   logic             dv1_vld, dv2_vld;
   logic [DVD_W-1:0] dv1_q, dv2_q;
   div_side_type     dv1_side;
   logic             dv2_neg;
   assign root_den = {amag, 8'b0};

   qra_div #(
      .NUM_W  (DVD_W),
      .DEN_W  (DEN_W),
      .SIDE_W ($bits(div_side_type))
   ) u_div_first (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (n1_vld_ff),
      .num       (n1_dvd1_ff),
      .den       (root_den),
      .in_side   (n1_side_ff),
      .out_valid (dv1_vld),
      .quot      (dv1_q),
      .out_side  (dv1_side)
   );

   qra_div #(
      .NUM_W  (DVD_W),
      .DEN_W  (DEN_W),
      .SIDE_W (1)
   ) u_div_second (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (n1_vld_ff),
      .num       (n1_dvd2_ff),
      .den       (root_den),
      .in_side   (n1_side_ff.neg_second),
      .out_valid (dv2_vld),
      .quot      (dv2_q),
      .out_side  (dv2_neg)
   );

   // Clip a rounded quotient to the signed root range and apply its sign.
   function automatic logic [RW:0] clip_root(input logic [DVD_W-1:0] q, input logic neg);
      logic [DVD_W-1:0] qc;
      logic             sat;
      logic [RW-1:0]    r;
      sat = 1'b0;
      qc  = q;
      if (neg) begin
         if (q > NEG_LIM) begin
            qc  = NEG_LIM;
            sat = 1'b1;
         end
         r = RW'(0) - qc[RW-1:0];
      end else begin
         if (q > POS_LIM) begin
            qc  = POS_LIM;
            sat = 1'b1;
         end
         r = qc[RW-1:0];
      end
      return {sat, r};
   endfunction

   // Root results stage.
   logic [RW:0]   clip1, clip2;
   logic          r_vld_ff;
   roots_type     r_roots_ff;
   logic [BW-1:0] r_lo_ff, r_hi_ff;

   assign clip1 = clip_root(dv1_q, dv1_side.neg_first);
   assign clip2 = clip_root(dv2_q, dv2_neg);

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
      end else if (adv) begin
         r_vld_ff <= dv1_vld && dv2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_lo_ff           <= dv1_side.base.lo_bound;
         r_hi_ff           <= dv1_side.base.hi_bound;
         r_roots_ff.first  <= clip1[RW-1:0];
         r_roots_ff.sat    <= clip1[RW] | clip2[RW];
         if (dv1_side.base.dneg) begin
            r_roots_ff.count  <= qra_pkg::ROOTS_NONE;
            r_roots_ff.second <= clip1[RW-1:0];
            r_roots_ff.imag   <= clip2[RW-1:0];
         end else begin
            r_roots_ff.count  <= dv1_side.base.dzero ? qra_pkg::ROOTS_ONE : qra_pkg::ROOTS_TWO;
            r_roots_ff.second <= clip2[RW-1:0];
            r_roots_ff.imag   <= '0;
         end
      end
   end

   // Area path sideband and valid travel through eight stages.
   logic      e_vld_ff   [ESTG];
   roots_type e_roots_ff [ESTG];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ESTG; j++) e_vld_ff[j] <= 1'b0;
      end else if (adv) begin
         e_vld_ff[0] <= r_vld_ff;
         for (int j = 1; j < ESTG; j++) e_vld_ff[j] <= e_vld_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_roots_ff[0] <= r_roots_ff;
         for (int j = 1; j < ESTG; j++) e_roots_ff[j] <= e_roots_ff[j-1];
      end
   end

   // Area stage zero: split the interval at roots that lie strictly inside it.
   logic signed [RW-1:0] rt1, rt2, rlo, rhi, bx, by, pl, ph;
   logic                 two, none, lo_only, hi_only, use_lo, use_hi;
   logic signed [RW-1:0] pt_ff [NPT];

   always_comb begin
      rt1     = r_roots_ff.first;
      rt2     = r_roots_ff.second;
      rlo     = (rt1 < rt2) ? rt1 : rt2;
      rhi     = (rt1 < rt2) ? rt2 : rt1;
      bx      = RW'(signed'(r_lo_ff));
      by      = RW'(signed'(r_hi_ff));
      two     = (r_roots_ff.count == qra_pkg::ROOTS_TWO);
      none    = (by <= rlo) || ((bx >= rlo) && (by <= rhi)) || (bx >= rhi);
      lo_only = (bx < rlo) && (by <= rhi);
      hi_only = (bx >= rlo) && (by > rhi);
      use_lo  = two && !none && !hi_only;
      use_hi  = two && !none && !lo_only;
      pl      = use_lo ? rlo : bx;
      ph      = use_hi ? rhi : pl;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pt_ff[0] <= bx;
         pt_ff[1] <= pl;
         pt_ff[2] <= ph;
         pt_ff[3] <= by;
      end
   end

   // Area stage one: point magnitudes and first products.
   logic [RW-1:0]      tm_cur [NPT];
   logic [RW-1:0]      tm_ff  [NPT];
   logic               tn1_ff [NPT];
   logic [2*RW-1:0]    t2_ff  [NPT];
   logic [CW+RW-1:0]   at_ff  [NPT];
   logic [CW+RW-1:0]   bt_ff  [NPT];
   logic [CW+RW-1:0]   ct_ff  [NPT];

   always_comb begin
      for (int i = 0; i < NPT; i++) begin
         tm_cur[i] = pt_ff[i][RW-1] ? RW'(0) - pt_ff[i] : pt_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NPT; i++) begin
            tm_ff[i]  <= tm_cur[i];
            tn1_ff[i] <= pt_ff[i][RW-1];
            t2_ff[i]  <= tm_cur[i] * tm_cur[i];
            at_ff[i]  <= amag * tm_cur[i];
            bt_ff[i]  <= bmag * tm_cur[i];
            ct_ff[i]  <= cmag * tm_cur[i];
         end
      end
   end

   // Area stage two: partial products of 2*a*t^3 and 3*b*t^2, and 6*c*t.
   logic [CW+RW:0]   a2  [NPT];
   logic [CW+RW+1:0] b3  [NPT];
   logic [63:0]      pll_ff [NPT];
   logic [63:0]      plh_ff [NPT];
   logic [CW+RW:0]   phl_ff [NPT];
   logic [CW+RW:0]   phh_ff [NPT];
   logic [63:0]      ql_ff  [NPT];
   logic [CW+RW+1:0] qh_ff  [NPT];
   logic [CW+RW+2:0] c6_ff  [NPT];
   logic             tn2_ff [NPT];

   always_comb begin
      for (int i = 0; i < NPT; i++) begin
         a2[i] = {at_ff[i], 1'b0};
         b3[i] = {2'b00, bt_ff[i]} + {1'b0, bt_ff[i], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NPT; i++) begin
            pll_ff[i] <= a2[i][31:0] * t2_ff[i][31:0];
            plh_ff[i] <= a2[i][31:0] * t2_ff[i][63:32];
            phl_ff[i] <= a2[i][CW+RW:32] * t2_ff[i][31:0];
            phh_ff[i] <= a2[i][CW+RW:32] * t2_ff[i][63:32];
            ql_ff[i]  <= b3[i][31:0] * tm_ff[i];
            qh_ff[i]  <= b3[i][CW+RW+1:32] * tm_ff[i];
            c6_ff[i]  <= {1'b0, ct_ff[i], 2'b00} + {2'b00, ct_ff[i], 1'b0};
            tn2_ff[i] <= tn1_ff[i];
         end
      end
   end

   // Area stage three: assemble the three term magnitudes.
   logic [WW-1:0] m1_ff [NPT];
   logic [WW-1:0] m2_ff [NPT];
   logic [WW-1:0] m3_ff [NPT];
   logic          tn3_ff [NPT];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NPT; i++) begin
            m1_ff[i]  <= WW'(pll_ff[i]) + (WW'(plh_ff[i]) << 32) + (WW'(phl_ff[i]) << 32)
                         + (WW'(phh_ff[i]) << 64);
            m2_ff[i]  <= (WW'(ql_ff[i]) + (WW'(qh_ff[i]) << 32)) << FRAC_BITS;
            m3_ff[i]  <= WW'(c6_ff[i]) << (2 * FRAC_BITS);
            tn3_ff[i] <= tn2_ff[i];
         end
      end
   end

   // Area stage four: signed antiderivative, scaled by six.
   logic [WW-1:0] v1 [NPT];
   logic [WW-1:0] v2 [NPT];
   logic [WW-1:0] v3 [NPT];
   logic [WW-1:0] anti_ff [NPT];

   always_comb begin
      for (int i = 0; i < NPT; i++) begin
         v1[i] = (coef_quad_ff[CW-1] ^ tn3_ff[i]) ? WW'(0) - m1_ff[i] : m1_ff[i];
         v2[i] = coef_lin_ff[CW-1] ? WW'(0) - m2_ff[i] : m2_ff[i];
         v3[i] = (coef_const_ff[CW-1] ^ tn3_ff[i]) ? WW'(0) - m3_ff[i] : m3_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NPT; i++) anti_ff[i] <= v1[i] + v2[i] + v3[i];
      end
   end

   // Area stage five: segment differences.
   logic [WW-1:0] diff_ff [NSEG];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < NSEG; j++) diff_ff[j] <= anti_ff[j+1] - anti_ff[j];
      end
   end

   // Area stage six: segment magnitudes.
   logic [WW-1:0] absd_ff [NSEG];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < NSEG; j++) begin
            absd_ff[j] <= diff_ff[j][WW-1] ? WW'(0) - diff_ff[j] : diff_ff[j];
         end
      end
   end

   // Area stage seven: total plus the rounding half.
   logic [WW-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= absd_ff[0] + absd_ff[1] + absd_ff[2] + HALF;
      end
   end

   // Drop the fraction and check the range. Dividing by six is halving and then
   // a multiply by the reciprocal of three, split into four partial products.
   logic [WW-1:0]  sum_shr;
   logic [57:0]    half_sum;
   logic           area_sat;
   logic           rc_vld_ff;
   area_side_type  rc_side_ff;
   logic [63:0]    rc_ll_ff;
   logic [57:0]    rc_lh_ff, rc_hl_ff;
   logic [51:0]    rc_hh_ff;
   logic [115:0]   rc_prod;

   assign sum_shr  = sum_ff >> (3 * FRAC_BITS);
   assign half_sum = sum_shr[58:1];
   assign area_sat = (sum_shr[WW-1:64] != '0) || (sum_shr[63:0] >= AREA_LIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_vld_ff <= 1'b0;
      end else if (adv) begin
         rc_vld_ff <= e_vld_ff[ESTG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rc_ll_ff            <= half_sum[31:0] * RECIP3[31:0];
         rc_lh_ff            <= half_sum[31:0] * RECIP3[57:32];
         rc_hl_ff            <= half_sum[57:32] * RECIP3[31:0];
         rc_hh_ff            <= half_sum[57:32] * RECIP3[57:32];
         rc_side_ff.roots    <= e_roots_ff[ESTG-1];
         rc_side_ff.area_sat <= area_sat;
      end
   end

   assign rc_prod = 116'(rc_ll_ff) + (116'(rc_lh_ff) << 32) + (116'(rc_hl_ff) << 32)
                    + (116'(rc_hh_ff) << 64);

   // Output register.
   logic [qra_pkg::AREA_W-1:0] rsp_area_ff;
   roots_type                  rsp_roots_ff;
   logic                       rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rc_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_area_ff  <= rc_side_ff.area_sat ? '1 :
                         rc_prod[RC_SHIFT+qra_pkg::AREA_W-1:RC_SHIFT];
         rsp_roots_ff <= rc_side_ff.roots;
         rsp_sat_ff   <= rc_side_ff.area_sat | rc_side_ff.roots.sat;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_area            = rsp_area_ff;
   assign rsp_real_root_count = rsp_roots_ff.count;
   assign rsp_root_first      = rsp_roots_ff.first;
   assign rsp_root_second     = rsp_roots_ff.second;
   assign rsp_root_imag       = rsp_roots_ff.imag;
   assign rsp_saturated       = rsp_sat_ff;

   // The root count is always one of the three legal codes.
   a_count_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_real_root_count == qra_pkg::ROOTS_NONE ||
                     rsp_real_root_count == qra_pkg::ROOTS_ONE ||
                     rsp_real_root_count == qra_pkg::ROOTS_TWO))
      else $error("root count out of range");

   // Real roots carry no imaginary part.
   a_imag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_real_root_count != qra_pkg::ROOTS_NONE) |-> rsp_root_imag == '0)
      else $error("imaginary part set for real roots");

   // Complex roots share one real part.
   a_complex_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_real_root_count == qra_pkg::ROOTS_NONE) |->
      rsp_root_first == rsp_root_second)
      else $error("complex roots with different real parts");

   // The quadratic coefficient never becomes zero.
   a_quad_nonzero: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> coef_quad_ff != '0)
      else $error("quadratic coefficient is zero");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the quadratic roots and area unit.
// Depends on qra_pkg and quadratic_roots_and_area_unit; drives directed and random words.
`timescale 1ns / 1ps

module tb_top;

   localparam int FRAC = 16;
   localparam int PIPE_LATENCY = 80 + FRAC;
   localparam longint unsigned AREA_TOP = 64'h00FF_FFFF_FFFF_FFFF;
   localparam logic [qra_pkg::CSR_W-1:0] CSR_SPARE = 2'd3;
   localparam int RANDOM_WORDS = 1850;

   typedef struct packed {
      logic [qra_pkg::AREA_W-1:0] area;
      logic [qra_pkg::CNT_W-1:0]  count;
      logic [qra_pkg::ROOT_W-1:0] first;
      logic [qra_pkg::ROOT_W-1:0] second;
      logic [qra_pkg::ROOT_W-1:0] imag;
      logic                       sat;
   } roots_area_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                kind;
      logic [qra_pkg::CSR_W-1:0]   idx;
      logic signed [23:0]          v0;
      logic signed [23:0]          v1;
      bit                          fixed;
      roots_area_type              res;
   } plan_row_type;

   localparam roots_area_type NO_RES = '0;

   logic clock = 0;
   logic reset = 1;
   logic req_valid, req_stall, rsp_valid;
   logic rsp_stall = 0;
   logic signed [qra_pkg::BOUND_W-1:0] req_bound_from, req_bound_to;
   logic [qra_pkg::AREA_W-1:0] rsp_area;
   logic [qra_pkg::CNT_W-1:0] rsp_real_root_count;
   logic signed [qra_pkg::ROOT_W-1:0] rsp_root_first, rsp_root_second, rsp_root_imag;
   logic rsp_saturated;
   logic csr_write;
   logic [qra_pkg::CSR_W-1:0] csr_index;
   logic [qra_pkg::COEF_W-1:0] csr_wdata;

   // Coefficients as the block should hold them.
   longint signed coef_a, coef_b, coef_c;

   roots_area_type pending_results[$];
   int mismatches = 0;
   int burst_left = 0;
   longint unsigned stall_cycle = 0;

   quadratic_roots_and_area_unit #(.FRAC_BITS(FRAC)) uut (.*);

   always #4 clock = ~clock;

   function automatic longint unsigned magnitude(longint signed v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // Rounded quotient num * 2^F / (2a * 2^7), clipped to the signed 32-bit range.
   function automatic longint signed root_quotient(longint signed num, inout bit sat);
      longint unsigned dm, q;
      bit neg;
      dm = magnitude(coef_a) << 8;
      q = ((magnitude(num) << FRAC) + (dm >> 1)) / dm;
      neg = (num < 0) != (coef_a < 0);
      if (neg) begin
         if (q > 64'h8000_0000) begin
            sat = 1;
            q = 64'h8000_0000;
         end
         return -longint'(q);
      end
      if (q > 64'h7FFF_FFFF) begin
         sat = 1;
         q = 64'h7FFF_FFFF;
      end
      return longint'(q);
   endfunction

   // Six times the antiderivative at t, scaled by 2^(4F), exact.
   function automatic logic signed [127:0] antideriv6(longint signed t);
      logic signed [127:0] wa, wb, wc, wt;
      wa = coef_a;
      wb = coef_b;
      wc = coef_c;
      wt = t;
      return 2 * wa * wt * wt * wt + 3 * wb * wt * wt * 128'sd65536
         + 6 * wc * wt * 128'sd4294967296;
   endfunction

   function automatic roots_area_type predict_roots_area(longint signed x, longint signed y);
      roots_area_type r;
      longint signed d, s, nb, r1, r2, ri, tmp, lo, hi;
      longint signed pts[4];
      int np;
      bit sat;
      logic signed [127:0] dv;
      logic [127:0] sum, tq;
      longint unsigned ar;
      logic [qra_pkg::CNT_W-1:0] cnt;
      ri = 0;
      sat = 0;
      d = coef_b * coef_b - 4 * coef_a * coef_c;
      s = longint'(sqrt_floor(magnitude(d) << 14));
      nb = -coef_b * 128;
      if (y < x) begin
         tmp = x;
         x = y;
         y = tmp;
      end
      if (d < 0) begin
         cnt = qra_pkg::ROOTS_NONE;
         r1 = root_quotient(nb, sat);
         r2 = r1;
         ri = root_quotient(s, sat);
      end else begin
         cnt = d > 0 ? qra_pkg::ROOTS_TWO : qra_pkg::ROOTS_ONE;
         r1 = root_quotient(nb - s, sat);
         r2 = root_quotient(nb + s, sat);
      end
      // Split the interval at the roots that fall strictly inside it.
      np = 0;
      pts[np++] = x;
      if (cnt == qra_pkg::ROOTS_TWO) begin
         lo = r1 < r2 ? r1 : r2;
         hi = r1 < r2 ? r2 : r1;
         if (y <= lo || (x >= lo && y <= hi) || x >= hi) begin
         end else if (x < lo && y <= hi) begin
            pts[np++] = lo;
         end else if (x >= lo && y > hi) begin
            pts[np++] = hi;
         end else begin
            pts[np++] = lo;
            pts[np++] = hi;
         end
      end
      pts[np++] = y;
      sum = 0;
      for (int i = 0; i + 1 < np; i++) begin
         dv = antideriv6(pts[i + 1]) - antideriv6(pts[i]);
         if (dv < 0) dv = -dv;
         sum += dv;
      end
      tq = (sum + (128'd3 << 48)) >> 48;
      if (tq[127:64] != 0) begin
         ar = AREA_TOP;
         sat = 1;
      end else begin
         ar = tq[63:0] / 6;
         if (ar > AREA_TOP) begin
            ar = AREA_TOP;
            sat = 1;
         end
      end
      r.area = ar[qra_pkg::AREA_W-1:0];
      r.count = cnt;
      r.first = r1[31:0];
      r.second = r2[31:0];
      r.imag = ri[31:0];
      r.sat = sat;
      return r;
   endfunction

   // Send one word, with bursts and gaps on the request side.
   task automatic send_word(logic signed [23:0] f, logic signed [23:0] t, bit fixed,
                            roots_area_type lit);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock) req_valid <= 0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1;
      req_bound_from <= f;
      req_bound_to <= t;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      pending_results.push_back(fixed ? lit : predict_roots_area(f, t));
   endtask

   // Coefficients change only with the pipeline drained.
   task automatic write_coef(logic [qra_pkg::CSR_W-1:0] idx, logic signed [23:0] v);
      @(negedge clock) req_valid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock) csr_write <= 0;
      if (idx == qra_pkg::CSR_COEF_QUAD && v != 0) coef_a = v;
      else if (idx == qra_pkg::CSR_COEF_LIN) coef_b = v;
      else if (idx == qra_pkg::CSR_COEF_CONST) coef_c = v;
   endtask

   function automatic logic signed [23:0] pick_coef();
      case ($urandom_range(0, 9))
         0: return 24'sh800000;
         1: return 24'sh7FFFFF;
         2: return ($urandom_range(0, 1) ? 24'sd1 : -24'sd1);
         3, 4, 5: return 24'($urandom());
         default: return $signed(24'($urandom_range(0, 1048576))) - 24'sd524288;
      endcase
   endfunction

   function automatic logic signed [23:0] clip24(longint signed v);
      if (v > 8388607) return 24'sh7FFFFF;
      if (v < -8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   // Receiver stalls follow a pattern that changes with the upper bits of a free-running cycle counter.
   always @(negedge clock) begin
      stall_cycle <= stall_cycle + 1;
      case (stall_cycle[10:9])
         2'd0: rsp_stall <= 0;
         2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2: rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= ((stall_cycle % 7) < 3);
      endcase
   end

   // Compare each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      roots_area_type want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_area, rsp_real_root_count, rsp_root_first, rsp_root_second,
                 rsp_root_imag, rsp_saturated};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result word: %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %p, actual %p", want, got);
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      plan_row_type plan[] = '{
         '{ROW_WORD, CSR_SPARE, 24'sd0, 24'sd0, 1,
           '{56'd0, qra_pkg::ROOTS_ONE, 32'd0, 32'd0, 32'd0, 1'b0}},
         '{ROW_WORD, CSR_SPARE, 24'sd0, 24'sd65536, 1,
           '{56'd21845, qra_pkg::ROOTS_ONE, 32'd0, 32'd0, 32'd0, 1'b0}},
         '{ROW_WORD, CSR_SPARE, 24'sd65536, 24'sd0, 1,
           '{56'd21845, qra_pkg::ROOTS_ONE, 32'd0, 32'd0, 32'd0, 1'b0}},
         '{ROW_WORD, CSR_SPARE, 24'sh800000, 24'sh7FFFFF, 0, NO_RES},
         '{ROW_WORD, CSR_SPARE, 24'sh7FFFFF, 24'sh7FFFFF, 1,
           '{56'd0, qra_pkg::ROOTS_ONE, 32'd0, 32'd0, 32'd0, 1'b0}},
         '{ROW_CSR, qra_pkg::CSR_COEF_QUAD, 24'sd0, 24'sd0, 0, NO_RES},
         '{ROW_WORD, CSR_SPARE, 24'sd0, 24'sd65536, 1,
           '{56'd21845, qra_pkg::ROOTS_ONE, 32'd0, 32'd0, 32'd0, 1'b0}},
         '{ROW_CSR, CSR_SPARE, 24'sd12345, 24'sd0, 0, NO_RES},
         '{ROW_CSR, qra_pkg::CSR_COEF_CONST, -24'sd65536, 24'sd0, 0, NO_RES},
         '{ROW_WORD, CSR_SPARE, -24'sd131072, 24'sd131072, 0, NO_RES},
         '{ROW_WORD, CSR_SPARE, -24'sd131072, 24'sd0, 0, NO_RES},
         '{ROW_WORD, CSR_SPARE, 24'sd131072, 24'sd0, 0, NO_RES},
         '{ROW_WORD, CSR_SPARE, -24'sd32768, 24'sd32768, 0, NO_RES},
         '{ROW_CSR, qra_pkg::CSR_COEF_CONST, 24'sd65536, 24'sd0, 0, NO_RES},
         '{ROW_WORD, CSR_SPARE, -24'sd65536, 24'sd65536, 0, NO_RES},
         '{ROW_CSR, qra_pkg::CSR_COEF_QUAD, 24'sh800000, 24'sd0, 0, NO_RES},
         '{ROW_CSR, qra_pkg::CSR_COEF_LIN, 24'sh7FFFFF, 24'sd0, 0, NO_RES},
         '{ROW_CSR, qra_pkg::CSR_COEF_CONST, 24'sh800000, 24'sd0, 0, NO_RES},
         '{ROW_WORD, CSR_SPARE, 24'sh800000, 24'sh7FFFFF, 0, NO_RES},
         '{ROW_WORD, CSR_SPARE, 24'sh7FFFFF, 24'sh800000, 0, NO_RES},
         '{ROW_CSR, qra_pkg::CSR_COEF_QUAD, 24'sd1, 24'sd0, 0, NO_RES},
         '{ROW_CSR, qra_pkg::CSR_COEF_LIN, 24'sh800000, 24'sd0, 0, NO_RES},
         '{ROW_CSR, qra_pkg::CSR_COEF_CONST, 24'sh7FFFFF, 24'sd0, 0, NO_RES},
         '{ROW_WORD, CSR_SPARE, 24'sh800000, 24'sh7FFFFF, 0, NO_RES},
         '{ROW_WORD, CSR_SPARE, -24'sd1, 24'sd1, 0, NO_RES}
      };
      int sent;
      int phase_words;
      longint signed r1, r2;
      roots_area_type guide;
      logic signed [23:0] f, t;

      req_valid = 0;
      req_bound_from = 0;
      req_bound_to = 0;
      csr_write = 0;
      csr_index = qra_pkg::CSR_COEF_QUAD;
      csr_wdata = 0;
      coef_a = 65536;
      coef_b = 0;
      coef_c = 0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 0;

      // Directed table: extremes, swapped bounds, root splits, ignored writes.
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_coef(plan[i].idx, plan[i].v0);
         else send_word(plan[i].v0, plan[i].v1, plan[i].fixed, plan[i].res);
      end

      // Random phases, each with fresh coefficients.
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         write_coef(qra_pkg::CSR_COEF_QUAD, pick_coef());
         write_coef(qra_pkg::CSR_COEF_LIN, pick_coef());
         write_coef(qra_pkg::CSR_COEF_CONST, pick_coef());
         guide = predict_roots_area(0, 0);
         r1 = $signed(guide.first);
         r2 = $signed(guide.second);
         phase_words = $urandom_range(40, 160);
         if (phase_words > RANDOM_WORDS - sent) phase_words = RANDOM_WORDS - sent;
         repeat (phase_words) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  f = 24'($urandom());
                  t = 24'($urandom());
               end
               5, 6, 7: begin
                  f = $signed(24'($urandom_range(0, 524288))) - 24'sd262144;
                  t = $signed(24'($urandom_range(0, 524288))) - 24'sd262144;
               end
               default: begin
                  f = clip24(r1 + $signed(32'($urandom_range(0, 2000))) - 1000);
                  t = clip24(r2 + $signed(32'($urandom_range(0, 2000))) - 1000);
               end
            endcase
            send_word(f, t, 0, NO_RES);
            sent++;
         end
      end

      @(negedge clock) req_valid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 20) @(posedge clock);
      if (mismatches == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
rtl/qra_pkg.sv
rtl/qra_sqrt.sv
rtl/qra_div.sv
rtl/quadratic_roots_and_area_unit.sv
test/tb_top.sv
